@@ src/cdd_pkg.sv @@
// Shared types, constants and month table for the calendar date decrementer.
package cdd_pkg;

    localparam int ACTION_W = 4;
    localparam int COUNT_W  = 16;
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 16;
    localparam int MULT_W   = 10;
    // remaining day count: up to 65535 weeks of 7 days
    localparam int N_W      = 19;

    localparam logic [ACTION_W-1:0] ACT_LOAD         = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_DAYS         = 4'd1;
    localparam logic [ACTION_W-1:0] ACT_WEEKS        = 4'd2;
    localparam logic [ACTION_W-1:0] ACT_MONTHS       = 4'd3;
    localparam logic [ACTION_W-1:0] ACT_YEARS_STEP   = 4'd4;
    localparam logic [ACTION_W-1:0] ACT_YEARS_ONCE   = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_DECADES_STEP = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_DECADES_ONCE = 4'd7;
    localparam logic [ACTION_W-1:0] ACT_CENTURIES    = 4'd8;
    localparam logic [ACTION_W-1:0] ACT_MILLENNIA    = 4'd9;

    localparam logic [MULT_W-1:0] MULT_ONE        = 10'd1;
    localparam logic [MULT_W-1:0] MULT_WEEK       = 10'd7;
    localparam logic [MULT_W-1:0] MULT_DECADE     = 10'd10;
    localparam logic [MULT_W-1:0] MULT_CENTURY    = 10'd100;
    localparam logic [MULT_W-1:0] MULT_MILLENNIUM = 10'd1000;

    localparam logic [DAY_W-1:0]   DAY_RESET   = 5'd1;
    localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;
    localparam logic [YEAR_W-1:0]  YEAR_RESET  = 16'd2000;

    // multiply-by-inverse divisibility test: u % 25 == 0 iff (u * INV25) mod 2^16 <= DIV25_MAX
    localparam logic [15:0] INV25     = 16'd23593;
    localparam logic [15:0] DIV25_MAX = 16'd2621;

    typedef enum logic [2:0] {
        OP_NONE      = 3'd0,
        OP_LOAD      = 3'd1,
        OP_SET_N     = 3'd2,
        OP_DAY       = 3'd3,
        OP_MONTH     = 3'd4,
        OP_YEAR_STEP = 3'd5,
        OP_YEAR_ONCE = 3'd6
    } cdd_op_t;

    typedef struct packed {
        cdd_op_t            op;
        logic [MULT_W-1:0]  mult;
    } cdd_ctrl_t;

    // common-year month lengths, 31 for codes outside 1..12
    function automatic logic [DAY_W-1:0] common_month_days(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] d;
        case (m)
            4'd1:    d = 5'd31;
            4'd2:    d = 5'd28;
            4'd3:    d = 5'd31;
            4'd4:    d = 5'd30;
            4'd5:    d = 5'd31;
            4'd6:    d = 5'd30;
            4'd7:    d = 5'd31;
            4'd8:    d = 5'd31;
            4'd9:    d = 5'd30;
            4'd10:   d = 5'd31;
            4'd11:   d = 5'd30;
            4'd12:   d = 5'd31;
            default: d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

@@ src/cdd_month_len.sv @@
// Month length for a signed year and month, with the Gregorian leap rule.
module cdd_month_len (
    input  logic [cdd_pkg::YEAR_W-1:0]  year,
    input  logic [cdd_pkg::MONTH_W-1:0] month,
    output logic [cdd_pkg::DAY_W-1:0]   days
);

    logic [cdd_pkg::YEAR_W-1:0]   abs_year;
    logic [2*cdd_pkg::YEAR_W-1:0] prod;
    logic                         div4;
    logic                         div16;
    logic                         div25;
    logic                         leap;

    // two's complement keeps the low bits, so mod 4 and mod 16 read directly
    assign div4     = (year[1:0] == 2'b00);
    assign div16    = (year[3:0] == 4'b0000);
    assign abs_year = year[cdd_pkg::YEAR_W-1] ? (~year + 16'd1) : year;
    assign prod     = abs_year * cdd_pkg::INV25;
    assign div25    = (prod[cdd_pkg::YEAR_W-1:0] <= cdd_pkg::DIV25_MAX);
    assign leap     = div4 && (!div25 || div16);

    always_comb begin
        if (month == cdd_pkg::MONTH_FEB && leap) begin
            days = 5'd29;
        end else begin
            days = cdd_pkg::common_month_days(month);
        end
    end

endmodule

@@ src/cdd_date_unit.sv @@
// Date registers and the shared step unit: one subtract-and-clamp per cycle.
module cdd_date_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cdd_pkg::cdd_ctrl_t            ctrl,
    input  logic [cdd_pkg::COUNT_W-1:0]   count,
    input  logic [cdd_pkg::DAY_W-1:0]     load_day,
    input  logic [cdd_pkg::MONTH_W-1:0]   load_month,
    input  logic [cdd_pkg::YEAR_W-1:0]    load_year,
    output logic                          n_zero,
    output logic [cdd_pkg::DAY_W-1:0]     day,
    output logic [cdd_pkg::MONTH_W-1:0]   month,
    output logic [cdd_pkg::YEAR_W-1:0]    year
);

    logic [cdd_pkg::DAY_W-1:0]   day_reg,   day_next;
    logic [cdd_pkg::MONTH_W-1:0] month_reg, month_next;
    logic [cdd_pkg::YEAR_W-1:0]  year_reg,  year_next;
    logic [cdd_pkg::N_W-1:0]     n_reg,     n_next;

    logic                                      wrap;
    logic [cdd_pkg::MONTH_W-1:0]               back_month;
    logic [cdd_pkg::YEAR_W-1:0]                year_sub;
    logic [cdd_pkg::YEAR_W-1:0]                year_new;
    logic [cdd_pkg::N_W-1:0]                   n_sub;
    logic [cdd_pkg::N_W:0]                     n_diff;
    logic                                      n_lt;
    logic [cdd_pkg::COUNT_W+cdd_pkg::MULT_W-1:0] scaled;
    logic [cdd_pkg::MONTH_W-1:0]               ld_month;
    logic [cdd_pkg::DAY_W-1:0]                 ld_day;
    logic [cdd_pkg::YEAR_W-1:0]                ml_year;
    logic [cdd_pkg::MONTH_W-1:0]               ml_month;
    logic [cdd_pkg::DAY_W-1:0]                 dim;
    logic [cdd_pkg::DAY_W-1:0]                 day_clamped;

    assign wrap       = (month_reg <= cdd_pkg::MONTH_FIRST);
    assign back_month = wrap ? cdd_pkg::MONTH_LAST : (month_reg - 4'd1);

    // shared year subtractor
    always_comb begin
        case (ctrl.op)
            cdd_pkg::OP_DAY,
            cdd_pkg::OP_MONTH:     year_sub = {15'd0, wrap};
            cdd_pkg::OP_YEAR_STEP: year_sub = {6'd0, ctrl.mult};
            cdd_pkg::OP_YEAR_ONCE: year_sub = n_reg[cdd_pkg::YEAR_W-1:0];
            default:               year_sub = '0;
        endcase
    end
    assign year_new = year_reg - year_sub;

    // shared count subtractor: days crossed, or one unit
    assign n_sub  = (ctrl.op == cdd_pkg::OP_DAY) ? {14'd0, day_reg} : 19'd1;
    assign n_diff = {1'b0, n_reg} - {1'b0, n_sub};
    assign n_lt   = n_diff[cdd_pkg::N_W];
    assign n_zero = (n_reg == '0);

    assign scaled = count * ctrl.mult;

    always_comb begin
        if (load_month == 4'd0) begin
            ld_month = cdd_pkg::MONTH_FIRST;
        end else if (load_month > cdd_pkg::MONTH_LAST) begin
            ld_month = cdd_pkg::MONTH_LAST;
        end else begin
            ld_month = load_month;
        end
        ld_day = (load_day == 5'd0) ? cdd_pkg::DAY_RESET : load_day;
    end

    // the single month-length unit looks at the date being landed on
    always_comb begin
        case (ctrl.op)
            cdd_pkg::OP_LOAD: begin
                ml_year  = load_year;
                ml_month = ld_month;
            end
            cdd_pkg::OP_DAY,
            cdd_pkg::OP_MONTH: begin
                ml_year  = year_new;
                ml_month = back_month;
            end
            default: begin
                ml_year  = year_new;
                ml_month = month_reg;
            end
        endcase
    end

    cdd_month_len u_month_len (
        .year  (ml_year),
        .month (ml_month),
        .days  (dim)
    );

    assign day_clamped = (day_reg > dim) ? dim : day_reg;

    always_comb begin
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        n_next     = n_reg;
        case (ctrl.op)
            cdd_pkg::OP_LOAD: begin
                month_next = ld_month;
                year_next  = load_year;
                day_next   = (ld_day > dim) ? dim : ld_day;
            end
            cdd_pkg::OP_SET_N: begin
                n_next = scaled[cdd_pkg::N_W-1:0];
            end
            cdd_pkg::OP_DAY: begin
                if (n_lt) begin
                    day_next = day_reg - n_reg[cdd_pkg::DAY_W-1:0];
                    n_next   = '0;
                end else begin
                    n_next     = n_diff[cdd_pkg::N_W-1:0];
                    month_next = back_month;
                    year_next  = year_new;
                    day_next   = dim;
                end
            end
            cdd_pkg::OP_MONTH: begin
                month_next = back_month;
                year_next  = year_new;
                day_next   = day_clamped;
                n_next     = n_diff[cdd_pkg::N_W-1:0];
            end
            cdd_pkg::OP_YEAR_STEP: begin
                year_next = year_new;
                day_next  = day_clamped;
                n_next    = n_diff[cdd_pkg::N_W-1:0];
            end
            cdd_pkg::OP_YEAR_ONCE: begin
                year_next = year_new;
                day_next  = day_clamped;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            day_reg   <= cdd_pkg::DAY_RESET;
            month_reg <= cdd_pkg::MONTH_FIRST;
            year_reg  <= cdd_pkg::YEAR_RESET;
        end else begin
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg <= n_next;
    end

    assign day   = day_reg;
    assign month = month_reg;
    assign year  = year_reg;

    a_date_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        day_reg != '0 && month_reg != '0 && month_reg <= cdd_pkg::MONTH_LAST)
        else $error("kept date left the valid range");

    a_day_progress: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == cdd_pkg::OP_DAY && !n_zero) |=> (n_reg < $past(n_reg)))
        else $error("day step did not reduce the remaining count");

    a_month_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == cdd_pkg::OP_MONTH) |=> (month_reg != $past(month_reg)))
        else $error("month step left the month unchanged");

endmodule

@@ src/cdd_seq.sv @@
// Sequencer: takes one transaction, drives the step unit, hands off the result.
module cdd_seq (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [cdd_pkg::ACTION_W-1:0]   action,
    input  logic                           n_zero,
    input  logic                           m_busy,
    output cdd_pkg::cdd_ctrl_t             ctrl,
    output logic                           emit
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SETUP = 5'b00010,
        ST_STEP  = 5'b00100,
        ST_ONCE  = 5'b01000,
        ST_EMIT  = 5'b10000
    } cdd_state_t;

    cdd_state_t                     st_reg, st_next;
    logic [cdd_pkg::ACTION_W-1:0]   action_reg;

    assign s_tready = (st_reg == ST_IDLE);

    always_comb begin
        st_next   = st_reg;
        ctrl.op   = cdd_pkg::OP_NONE;
        ctrl.mult = cdd_pkg::MULT_ONE;
        emit      = 1'b0;
        case (st_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    st_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                ctrl.op = cdd_pkg::OP_SET_N;
                st_next = ST_STEP;
                case (action_reg)
                    cdd_pkg::ACT_LOAD: begin
                        ctrl.op = cdd_pkg::OP_LOAD;
                        st_next = ST_EMIT;
                    end
                    cdd_pkg::ACT_DAYS,
                    cdd_pkg::ACT_MONTHS,
                    cdd_pkg::ACT_YEARS_STEP,
                    cdd_pkg::ACT_DECADES_STEP: begin
                        ctrl.mult = cdd_pkg::MULT_ONE;
                    end
                    cdd_pkg::ACT_WEEKS: begin
                        ctrl.mult = cdd_pkg::MULT_WEEK;
                    end
                    cdd_pkg::ACT_YEARS_ONCE: begin
                        ctrl.mult = cdd_pkg::MULT_ONE;
                        st_next   = ST_ONCE;
                    end
                    cdd_pkg::ACT_DECADES_ONCE: begin
                        ctrl.mult = cdd_pkg::MULT_DECADE;
                        st_next   = ST_ONCE;
                    end
                    cdd_pkg::ACT_CENTURIES: begin
                        ctrl.mult = cdd_pkg::MULT_CENTURY;
                        st_next   = ST_ONCE;
                    end
                    cdd_pkg::ACT_MILLENNIA: begin
                        ctrl.mult = cdd_pkg::MULT_MILLENNIUM;
                        st_next   = ST_ONCE;
                    end
                    default: begin
                        ctrl.op = cdd_pkg::OP_NONE;
                        st_next = ST_EMIT;
                    end
                endcase
            end
            ST_STEP: begin
                if (n_zero) begin
                    st_next = ST_EMIT;
                end else begin
                    case (action_reg)
                        cdd_pkg::ACT_DAYS,
                        cdd_pkg::ACT_WEEKS:        ctrl.op = cdd_pkg::OP_DAY;
                        cdd_pkg::ACT_MONTHS:       ctrl.op = cdd_pkg::OP_MONTH;
                        cdd_pkg::ACT_YEARS_STEP:   ctrl.op = cdd_pkg::OP_YEAR_STEP;
                        cdd_pkg::ACT_DECADES_STEP: begin
                            ctrl.op   = cdd_pkg::OP_YEAR_STEP;
                            ctrl.mult = cdd_pkg::MULT_DECADE;
                        end
                        default:                   st_next = ST_EMIT;
                    endcase
                end
            end
            ST_ONCE: begin
                ctrl.op = cdd_pkg::OP_YEAR_ONCE;
                st_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_busy) begin
                    emit    = 1'b1;
                    st_next = ST_IDLE;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
        end else begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            action_reg <= action;
        end
    end

    a_accept_setup: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (st_reg == ST_SETUP))
        else $error("accepted transaction did not start setup");

    a_step_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_STEP && n_zero) |=> (st_reg == ST_EMIT))
        else $error("stepping went on past a zero count");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> !m_busy)
        else $error("result written over a pending output");

endmodule

@@ src/calendar_date_decrementer.sv @@
// Top level of the calendar date decrementer: ports, item capture, output register.
//
// channel  direction  tuser        tdata (low bit first)
// s_       in         action[3:0]  count[15:0] load_day[20:16] load_month[24:21]
//                                  load_year[40:25], zero fill to 48 bits
// m_       out        -            day[4:0] month[8:5] year[24:9], zero fill to 32 bits
//
// Per transaction: after setup, load and unused actions go straight to emit;
// at-once year/decade/century/millennium steps pass through the once state;
// stepwise months, years and decades take one unit per cycle through the shared
// subtract-and-clamp unit; days and weeks cross one month per step, then take the rest.
// Reset (aresetn low, synchronous) sets the date to day 1, month 1, year 2000.
// A finished result waits in the output register; s_tready comes back as soon as
// it is stored, and a stalled m_tready only holds the block in its last state.
module calendar_date_decrementer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [3:0]  s_tuser,  // action[3:0]
    input  logic [47:0] s_tdata,  // count, load_day, load_month, load_year, zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata   // day, month, year, zero fill
);

    logic [cdd_pkg::COUNT_W-1:0] count_reg;
    logic [cdd_pkg::DAY_W-1:0]   ld_day_reg;
    logic [cdd_pkg::MONTH_W-1:0] ld_month_reg;
    logic [cdd_pkg::YEAR_W-1:0]  ld_year_reg;

    logic                        m_tvalid_reg, m_tvalid_next;
    logic [31:0]                 m_tdata_reg;

    cdd_pkg::cdd_ctrl_t          ctrl;
    logic                        n_zero;
    logic                        emit;
    logic                        m_busy;
    logic [cdd_pkg::DAY_W-1:0]   day;
    logic [cdd_pkg::MONTH_W-1:0] month;
    logic [cdd_pkg::YEAR_W-1:0]  year;

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            count_reg    <= s_tdata[15:0];
            ld_day_reg   <= s_tdata[20:16];
            ld_month_reg <= s_tdata[24:21];
            ld_year_reg  <= s_tdata[40:25];
        end
    end

    assign m_busy = m_tvalid_reg && !m_tready;

    cdd_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .action   (s_tuser),
        .n_zero   (n_zero),
        .m_busy   (m_busy),
        .ctrl     (ctrl),
        .emit     (emit)
    );

    cdd_date_unit u_date (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .count      (count_reg),
        .load_day   (ld_day_reg),
        .load_month (ld_month_reg),
        .load_year  (ld_year_reg),
        .n_zero     (n_zero),
        .day        (day),
        .month      (month),
        .year       (year)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= {7'd0, year, month, day};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ tb/testbench.sv @@
// Self-checking stream testbench for the calendar date decrementer.
module testbench;
    import cdd_pkg::*;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [COUNT_W-1:0]  count;
        logic [DAY_W-1:0]    load_day;
        logic [MONTH_W-1:0]  load_month;
        logic [YEAR_W-1:0]   load_year;
    } date_req_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    localparam logic [DAY_W-1:0] MONTH_LEN [12] =
        '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};
    localparam int LONG_HOLD = 400;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [3:0]  s_tuser = '0;   // action
    logic [47:0] s_tdata = '0;   // count, load_day, load_month, load_year, zero fill
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // day, month, year, zero fill

    calendar_date_decrementer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    date_req_t  pending_reqs[$];
    date_t      expected_dates[$];
    date_req_t  offered;
    date_t      want;
    idle_mode_t idle_mode = IDLE_NONE;
    bit         long_hold_req = 1'b0;
    int         hold_count = 0;
    int         mismatches = 0;

    // predicted date
    logic [DAY_W-1:0]   cur_day = DAY_RESET;
    logic [MONTH_W-1:0] cur_mon = MONTH_FIRST;
    logic [YEAR_W-1:0]  cur_year = YEAR_RESET;

    function automatic bit leap_year(logic [YEAR_W-1:0] y);
        int v;
        v = $signed(y);
        return ((v % 4 == 0) && (v % 100 != 0)) || (v % 400 == 0);
    endfunction

    function automatic logic [DAY_W-1:0] month_days(logic [YEAR_W-1:0] y,
                                                     logic [MONTH_W-1:0] m);
        if (m < MONTH_FIRST || m > MONTH_LAST)
            return 5'd31;
        if (m == MONTH_FEB)
            return leap_year(y) ? 5'd29 : 5'd28;
        return MONTH_LEN[m - 1];
    endfunction

    task automatic clamp_day();
        if (cur_day > month_days(cur_year, cur_mon))
            cur_day = month_days(cur_year, cur_mon);
    endtask

    task automatic back_month();
        if (cur_mon <= MONTH_FIRST) begin
            cur_mon = MONTH_LAST;
            cur_year = cur_year - 16'd1;
        end else begin
            cur_mon = cur_mon - 4'd1;
        end
    endtask

    task automatic rewind_days(int n);
        while (n > 0) begin
            if (n < cur_day) begin
                cur_day = cur_day - DAY_W'(n);
                n = 0;
            end else begin
                n = n - cur_day;
                back_month();
                cur_day = month_days(cur_year, cur_mon);
            end
        end
    endtask

    task automatic years_stepwise(int n, logic [MULT_W-1:0] unit);
        int i;
        for (i = 0; i < n; i++) begin
            cur_year = cur_year - YEAR_W'(unit);
            clamp_day();
        end
    endtask

    task automatic years_once(logic [COUNT_W-1:0] n, logic [MULT_W-1:0] unit);
        logic [31:0] span;
        span = n * unit;
        cur_year = cur_year - span[15:0];
        clamp_day();
    endtask

    task automatic step_calendar(date_req_t r);
        int i;
        logic [DAY_W-1:0]   d;
        logic [MONTH_W-1:0] m;
        case (r.action)
            ACT_LOAD: begin
                d = r.load_day;
                m = r.load_month;
                if (m < MONTH_FIRST) m = MONTH_FIRST;
                if (m > MONTH_LAST) m = MONTH_LAST;
                if (d < DAY_RESET) d = DAY_RESET;
                cur_year = r.load_year;
                cur_mon = m;
                cur_day = d;
                clamp_day();
            end
            ACT_DAYS:  rewind_days(int'(r.count));
            ACT_WEEKS: rewind_days(int'(r.count) * int'(MULT_WEEK));
            ACT_MONTHS: begin
                for (i = 0; i < int'(r.count); i++) begin
                    back_month();
                    clamp_day();
                end
            end
            ACT_YEARS_STEP:   years_stepwise(int'(r.count), MULT_ONE);
            ACT_YEARS_ONCE:   years_once(r.count, MULT_ONE);
            ACT_DECADES_STEP: years_stepwise(int'(r.count), MULT_DECADE);
            ACT_DECADES_ONCE: years_once(r.count, MULT_DECADE);
            ACT_CENTURIES:    years_once(r.count, MULT_CENTURY);
            ACT_MILLENNIA:    years_once(r.count, MULT_MILLENNIUM);
            default: ;
        endcase
        expected_dates.push_back('{year: cur_year, month: cur_mon, day: cur_day});
    endtask

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic queue_req(logic [ACTION_W-1:0] a, logic [COUNT_W-1:0] c,
                             logic [DAY_W-1:0] d = DAY_RESET,
                             logic [MONTH_W-1:0] m = MONTH_FIRST,
                             logic [YEAR_W-1:0] y = YEAR_RESET);
        pending_reqs.push_back('{action: a, count: c, load_day: d, load_month: m, load_year: y});
    endtask

    function automatic date_req_t random_req();
        date_req_t r;
        int pick;
        r.count = COUNT_W'($urandom_range(0, 40));
        r.load_day = DAY_W'($urandom_range(0, 31));
        r.load_month = MONTH_W'($urandom_range(0, 15));
        r.load_year = YEAR_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 16) begin
            r.action = ACT_LOAD;
            // leap day loads make the year steps clamp
            if ($urandom_range(0, 2) == 0) begin
                r.load_day = 5'd29;
                r.load_month = MONTH_FEB;
                if ($urandom_range(0, 1) == 0)
                    r.load_year = r.load_year & 16'hFFFC;
            end
        end else if (pick < 30) begin
            r.action = ACT_DAYS;
            r.count = ($urandom_range(0, 19) == 0) ? COUNT_W'($urandom)
                                                   : COUNT_W'($urandom_range(0, 400));
        end else if (pick < 40) begin
            r.action = ACT_WEEKS;
            r.count = ($urandom_range(0, 29) == 0) ? COUNT_W'($urandom)
                                                   : COUNT_W'($urandom_range(0, 60));
        end else if (pick < 50) begin
            r.action = ACT_MONTHS;
        end else if (pick < 58) begin
            r.action = ACT_YEARS_STEP;
        end else if (pick < 64) begin
            r.action = ACT_DECADES_STEP;
        end else if (pick < 92) begin
            r.count = COUNT_W'($urandom);
            case ($urandom_range(0, 3))
                0:       r.action = ACT_YEARS_ONCE;
                1:       r.action = ACT_DECADES_ONCE;
                2:       r.action = ACT_CENTURIES;
                default: r.action = ACT_MILLENNIA;
            endcase
        end else begin
            r.count = COUNT_W'($urandom);
            r.action = ACT_MILLENNIA + ACTION_W'($urandom_range(1, 6));
        end
        return r;
    endfunction

    function automatic bit sender_idles();
        return (idle_mode == IDLE_SENDER && $urandom_range(0, 99) < 81) ||
               (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 11);
    endfunction

    function automatic bit receiver_stalls();
        return (idle_mode == IDLE_RECEIVER && $urandom_range(0, 99) < 81) ||
               (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 11);
    endfunction

    // driver: predicts on each accepted transaction, then offers the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                step_calendar(offered);
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() != 0 && !sender_idles()) begin
                    offered = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= offered.action;
                    s_tdata <= {7'd0, offered.load_year, offered.load_month,
                                offered.load_day, offered.count};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: one long hold on request, otherwise random stalls per idle mode
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (long_hold_req && hold_count < LONG_HOLD) begin
            hold_count <= hold_count + 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !receiver_stalls();
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_dates.size() == 0) begin
                report_mismatch("result with no date expected");
            end else begin
                want = expected_dates.pop_front();
                if (m_tdata[4:0] !== want.day)
                    report_mismatch($sformatf("day %0d, expected %0d",
                                              m_tdata[4:0], want.day));
                if (m_tdata[8:5] !== want.month)
                    report_mismatch($sformatf("month %0d, expected %0d",
                                              m_tdata[8:5], want.month));
                if (m_tdata[24:9] !== want.year)
                    report_mismatch($sformatf("year %0d, expected %0d",
                                              $signed(m_tdata[24:9]), $signed(want.year)));
            end
        end
    end

    task automatic drain();
        do
            @(negedge aclk);
        while (pending_reqs.size() != 0 || s_tvalid || expected_dates.size() != 0);
    endtask

    initial begin
        int p;
        int k;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset date, unused code, zero count
        queue_req(~ACT_LOAD, 16'hFFFF);
        queue_req(ACT_DAYS, 16'd0);
        // load fixups: zero day and month, day past month end, month past 12
        queue_req(ACT_LOAD, 16'd0, 5'd0, 4'd0, 16'd0);
        queue_req(ACT_LOAD, 16'hFFFF, 5'd31, MONTH_FEB, 16'd2000);
        queue_req(ACT_LOAD, 16'd0, 5'd31, 4'd15, 16'h8000);
        // day step across the year and the 16-bit year wrap
        queue_req(ACT_LOAD, 16'd0, 5'd1, MONTH_FIRST, 16'h8000);
        queue_req(ACT_DAYS, 16'd1);
        queue_req(ACT_LOAD, 16'd0, 5'd31, MONTH_LAST, 16'h7FFF);
        queue_req(ACT_LOAD, 16'd0, 5'd31, MONTH_LAST, 16'hFFFF);
        // stepwise clamps at every year, at-once clamps only at the end
        queue_req(ACT_LOAD, 16'd0, 5'd29, MONTH_FEB, 16'd2004);
        queue_req(ACT_YEARS_STEP, 16'd4);
        queue_req(ACT_LOAD, 16'd0, 5'd29, MONTH_FEB, 16'd2004);
        queue_req(ACT_YEARS_ONCE, 16'd4);
        queue_req(ACT_LOAD, 16'd0, 5'd29, MONTH_FEB, 16'd2000);
        queue_req(ACT_CENTURIES, 16'd1);
        // month step onto shorter months
        queue_req(ACT_LOAD, 16'd0, 5'd31, 4'd3, 16'd2001);
        queue_req(ACT_MONTHS, 16'd1);
        queue_req(ACT_LOAD, 16'd0, 5'd31, 4'd5, 16'd2023);
        queue_req(ACT_MONTHS, 16'd1);
        // full counts on days, weeks, months, stepwise years and decades, at-once decades and millennia
        queue_req(ACT_MONTHS, 16'hFFFF);
        queue_req(ACT_YEARS_STEP, 16'hFFFF);
        queue_req(ACT_DECADES_STEP, 16'hFFFF);
        queue_req(ACT_DECADES_ONCE, 16'hFFFF);
        queue_req(ACT_MILLENNIA, 16'hFFFF);
        queue_req(ACT_WEEKS, 16'hFFFF);
        queue_req(ACT_DAYS, 16'hFFFF);
        drain();

        for (p = 0; p < 4; p++) begin
            idle_mode = idle_mode_t'(p);
            for (k = 0; k < 16; k++)
                pending_reqs.push_back(random_req());
            drain();
        end

        // receiver holds off while the sender keeps offering
        idle_mode = IDLE_NONE;
        long_hold_req = 1'b1;
        for (k = 0; k < 10; k++)
            pending_reqs.push_back(random_req());
        drain();

        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #100_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
